// ===== src/nlc_pkg.sv =====
`timescale 1ns / 1ps

package nlc_pkg;

    // Character codes of interest
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_CTRLZ = 8'd26;

    // Result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE     = 2'd0,
        CFG_STRIP    = 2'd1,
        CFG_ALLOWBIN = 2'd2,
        CFG_TRUNC    = 2'd3
    } cfg_index_t;

    // Input item codes
    typedef enum logic {
        ACT_DATA = 1'b0,
        ACT_EOS  = 1'b1
    } action_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // Conversion mode
    typedef enum logic {
        MODE_TO_LF   = 1'b0,
        MODE_TO_CRLF = 1'b1
    } mode_t;

    typedef struct packed {
        logic mode;
        logic strip_high_bit;
        logic allow_binary;
        logic truncate_at_ctrlz;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } res_t;

    // Results produced by one item, in order: slot 0 first
    typedef struct packed {
        logic [1:0] count;
        res_t       res1;
        res_t       res0;
    } push_t;

    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] fill;
    } queue_stat_t;

    // Binary bytes: below 7, 14 to 25, and above 126
    function automatic logic is_binary(input logic [7:0] c);
        is_binary = c inside {[8'd0:8'd6], [8'd14:8'd25], [8'd127:8'd255]};
    endfunction

    function automatic res_t make_res(input logic [1:0] k, input logic [7:0] b);
        res_t r;
        r.kind     = k;
        r.out_byte = b;
        r.last     = 1'b0;
        make_res   = r;
    endfunction

endpackage

// ===== src/nlc_core.sv =====
`timescale 1ns / 1ps

module nlc_core import nlc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       action,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output push_t      push
);

    logic pending_cr_reg, pending_cr_next;
    logic pending_ctrlz_reg, pending_ctrlz_next;
    logic stopped_reg, stopped_next;
    logic rejected_reg, rejected_next;

    // Conversion of one word: up to two results and the next stream state.
    always_comb
    begin
        logic [7:0] c;
        logic [1:0] n;
        res_t       r [2];

        c    = cfg.strip_high_bit ? {1'b0, in_byte[6:0]} : in_byte;
        n    = 2'd0;
        r[0] = '0;
        r[1] = '0;
        pending_cr_next    = pending_cr_reg;
        pending_ctrlz_next = pending_ctrlz_reg;
        stopped_next       = stopped_reg;
        rejected_next      = rejected_reg;

        if (action == ACT_EOS)
        begin
            if (cfg.mode == MODE_TO_LF && pending_cr_reg && !rejected_reg && !stopped_reg)
            begin
                r[n[0]] = make_res(KIND_DATA, CH_CR);
                n = n + 2'd1;
            end
            r[n[0]] = make_res(rejected_reg ? KIND_REJECT : KIND_DONE, 8'd0);
            n = n + 2'd1;
            pending_cr_next    = 1'b0;
            pending_ctrlz_next = 1'b0;
            stopped_next       = 1'b0;
            rejected_next      = 1'b0;
        end
        else if (stopped_reg || rejected_reg)
        begin
            // Stream already ended: swallow the byte.
        end
        else if (!cfg.allow_binary && is_binary(in_byte))
        begin
            rejected_next      = 1'b1;
            pending_cr_next    = 1'b0;
            pending_ctrlz_next = 1'b0;
        end
        else if (cfg.mode == MODE_TO_LF)
        begin
            // A held control-Z goes out ahead of the next accepted byte; end of stream or a binary byte drops it.
            if (pending_ctrlz_reg)
            begin
                r[n[0]] = make_res(KIND_DATA, CH_CTRLZ);
                n = n + 2'd1;
                pending_ctrlz_next = 1'b0;
            end
            if (c == CH_LF)
            begin
                r[n[0]] = make_res(KIND_DATA, CH_LF);
                n = n + 2'd1;
                pending_cr_next = 1'b0;
            end
            else
            begin
                if (pending_cr_reg)
                begin
                    r[n[0]] = make_res(KIND_DATA, CH_CR);
                    n = n + 2'd1;
                end
                if (c == CH_CR)
                begin
                    pending_cr_next = 1'b1;
                end
                else if (c == CH_CTRLZ)
                begin
                    pending_cr_next = 1'b0;
                    if (cfg.truncate_at_ctrlz)
                        stopped_next = 1'b1;
                    else
                        pending_ctrlz_next = 1'b1;
                end
                else
                begin
                    pending_cr_next = 1'b0;
                    r[n[0]] = make_res(KIND_DATA, c);
                    n = n + 2'd1;
                end
            end
        end
        else
        begin
            pending_ctrlz_next = 1'b0;
            if (c == CH_LF)
            begin
                if (!pending_cr_reg)
                begin
                    r[n[0]] = make_res(KIND_DATA, CH_CR);
                    n = n + 2'd1;
                end
                pending_cr_next = 1'b0;
                r[n[0]] = make_res(KIND_DATA, CH_LF);
                n = n + 2'd1;
            end
            else if (c == CH_CR)
            begin
                pending_cr_next = 1'b1;
                r[n[0]] = make_res(KIND_DATA, CH_CR);
                n = n + 2'd1;
            end
            else if (c == CH_CTRLZ && cfg.truncate_at_ctrlz)
            begin
                pending_cr_next = 1'b0;
                stopped_next    = 1'b1;
            end
            else
            begin
                pending_cr_next = 1'b0;
                r[n[0]] = make_res(KIND_DATA, c);
                n = n + 2'd1;
            end
        end

        // Mark the final result of this word.
        if (n == 2'd1)
            r[0].last = 1'b1;
        else if (n == 2'd2)
            r[1].last = 1'b1;

        push.count = n;
        push.res0  = r[0];
        push.res1  = r[1];
    end

    // Stream state advances only when the word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_cr_reg    <= 1'b0;
            pending_ctrlz_reg <= 1'b0;
            stopped_reg       <= 1'b0;
            rejected_reg      <= 1'b0;
        end
        else if (fire)
        begin
            pending_cr_reg    <= pending_cr_next;
            pending_ctrlz_reg <= pending_ctrlz_next;
            stopped_reg       <= stopped_next;
            rejected_reg      <= rejected_next;
        end
    end

endmodule

// ===== src/nlc_outq.sv =====
`timescale 1ns / 1ps

module nlc_outq import nlc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_en,
    input  push_t       push,
    output logic        out_valid,
    input  logic        out_stall,
    output res_t        head,
    output queue_stat_t stat
);

    res_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic [1:0]        n_push;
    logic              pop;

    assign n_push    = push_en ? push.count : 2'd0;
    assign out_valid = (fill_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = entry_reg[rd_ptr_reg];

    // Room for a full pair of words regardless of this cycle's pop; fill follows it.
    assign stat = {(fill_reg <= QCNT_W'(QUEUE_DEPTH - 2)), fill_reg};

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        fill_next   = fill_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage: one or two words written per cycle
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            entry_reg[wr_ptr_reg] <= push.res0;
        if (n_push == 2'd2)
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= push.res1;
    end

endmodule

// ===== src/newline_convert.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake                | Payload
// ---------+--------------------------+----------------------------
// input    | in_valid / in_stall      | action, in_byte
// output   | out_valid / out_stall    | kind, out_byte, last
// config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One input word a cycle while in_stall is low: a word is registered, converted
// in the next cycle and its results enter a four-word result queue, which
// drains one word a cycle while out_stall is low. A word giving two results
// (CR LF expansion, flushed CR) takes two queue slots; the queue absorbs it
// while it has room, otherwise the input is held until there is room.
// in_stall rises while a registered word waits for room for two results.
// Reset clears configuration, stream state and the queue; no sweep needed.

module newline_convert import nlc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data
);

    cfg_t        cfg_reg;
    logic        hold_valid_reg;
    logic        hold_action_reg;
    logic [7:0]  hold_byte_reg;
    logic        fire;
    push_t       push;
    res_t        head;
    queue_stat_t stat;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:     cfg_reg.mode              <= cfg_data;
                CFG_STRIP:    cfg_reg.strip_high_bit    <= cfg_data;
                CFG_ALLOWBIN: cfg_reg.allow_binary      <= cfg_data;
                CFG_TRUNC:    cfg_reg.truncate_at_ctrlz <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: advances whenever its word moves on to the queue.
    assign fire     = hold_valid_reg && stat.room;
    assign in_stall = hold_valid_reg && !stat.room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (!in_stall)
            hold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_action_reg <= action;
            hold_byte_reg   <= in_byte;
        end
    end

    nlc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .action  (hold_action_reg),
        .in_byte (hold_byte_reg),
        .cfg     (cfg_reg),
        .push    (push)
    );

    nlc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .stat      (stat)
    );

    assign kind     = head.kind;
    assign out_byte = head.out_byte;
    assign last     = head.last;

`ifndef SYNTH
    // A status word always closes its input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_DATA) |-> last)
        else $error("status result without last");

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.fill <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // A converted word lands in the queue: fill cannot shrink by more than a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (push.count != 2'd0) |=> out_valid)
        else $error("pushed result not visible");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import nlc_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 45;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       action    = ACT_DATA;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_MODE;
    logic       cfg_data  = 1'b0;

    // Predicted converter: its own copy of the settings and the stream state
    cfg_t conv_cfg        = '0;
    logic held_cr         = 1'b0;
    logic held_ctrlz      = 1'b0;
    logic stream_stopped  = 1'b0;
    logic stream_rejected = 1'b0;
    res_t converted_q[$];

    int fail_count    = 0;
    int in_gap_max    = 4;
    int out_wait_max  = 4;
    int out_wait_left = 0;
    int quiet_cycles  = 0;
    int stream_left   = 5;

    newline_convert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bytes below 7, from 14 to 25 and above 126 count as binary.
    function automatic logic raw_is_binary(input logic [7:0] b);
        return (b < 8'd7) || (b > CH_CR && b < CH_CTRLZ) || (b > 8'd126);
    endfunction

    function automatic res_t data_word(input logic [7:0] b);
        return res_t'{KIND_DATA, b, 1'b0};
    endfunction

    function automatic cfg_t make_cfg(input logic m, input logic s, input logic a,
                                      input logic t);
        cfg_t c;
        c.mode              = m;
        c.strip_high_bit    = s;
        c.allow_binary      = a;
        c.truncate_at_ctrlz = t;
        return c;
    endfunction

    // Works out the words that one accepted input word gives and queues them.
    task automatic convert_word(input action_t act, input logic [7:0] raw);
        res_t       words[$];
        logic [7:0] c;
        c = raw;
        if (act == ACT_EOS)
        begin
            // A CR held in to-LF mode is flushed ahead of the status word.
            if (conv_cfg.mode == MODE_TO_LF && held_cr && !stream_rejected && !stream_stopped)
                words.push_back(data_word(CH_CR));
            words.push_back(res_t'{stream_rejected ? KIND_REJECT : KIND_DONE, 8'h00, 1'b0});
            held_cr         = 1'b0;
            held_ctrlz      = 1'b0;
            stream_stopped  = 1'b0;
            stream_rejected = 1'b0;
        end
        else if (!stream_stopped && !stream_rejected)
        begin
            if (!conv_cfg.allow_binary && raw_is_binary(raw))
            begin
                stream_rejected = 1'b1;
                held_cr         = 1'b0;
                held_ctrlz      = 1'b0;
            end
            else
            begin
                if (conv_cfg.strip_high_bit)
                    c[7] = 1'b0;
                if (conv_cfg.mode == MODE_TO_LF)
                begin
                    // A held control-Z goes out once another accepted byte follows.
                    if (held_ctrlz)
                    begin
                        words.push_back(data_word(CH_CTRLZ));
                        held_ctrlz = 1'b0;
                    end
                    if (c == CH_LF)
                    begin
                        words.push_back(data_word(CH_LF));
                        held_cr = 1'b0;
                    end
                    else if (c == CH_CR)
                    begin
                        if (held_cr)
                            words.push_back(data_word(CH_CR));
                        held_cr = 1'b1;
                    end
                    else if (c == CH_CTRLZ)
                    begin
                        if (held_cr)
                            words.push_back(data_word(CH_CR));
                        held_cr = 1'b0;
                        if (conv_cfg.truncate_at_ctrlz)
                            stream_stopped = 1'b1;
                        else
                            held_ctrlz = 1'b1;
                    end
                    else
                    begin
                        if (held_cr)
                            words.push_back(data_word(CH_CR));
                        held_cr = 1'b0;
                        words.push_back(data_word(c));
                    end
                end
                else
                begin
                    // In to-CRLF mode the CR flag only records the previous byte.
                    held_ctrlz = 1'b0;
                    if (c == CH_LF)
                    begin
                        if (!held_cr)
                            words.push_back(data_word(CH_CR));
                        held_cr = 1'b0;
                        words.push_back(data_word(CH_LF));
                    end
                    else if (c == CH_CR)
                    begin
                        held_cr = 1'b1;
                        words.push_back(data_word(CH_CR));
                    end
                    else if (c == CH_CTRLZ && conv_cfg.truncate_at_ctrlz)
                    begin
                        held_cr        = 1'b0;
                        stream_stopped = 1'b1;
                    end
                    else
                    begin
                        held_cr = 1'b0;
                        words.push_back(data_word(c));
                    end
                end
            end
        end
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        foreach (words[i])
            converted_q.push_back(words[i]);
    endtask

    // Offers one input word after a random gap and holds it until taken.
    task automatic send_word(input action_t act, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        convert_word(act, b);
    endtask

    task automatic end_stream();
        send_word(ACT_EOS, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MODE:     conv_cfg.mode              = val;
            CFG_STRIP:    conv_cfg.strip_high_bit    = val;
            CFG_ALLOWBIN: conv_cfg.allow_binary      = val;
            CFG_TRUNC:    conv_cfg.truncate_at_ctrlz = val;
            default:      ;
        endcase
    endtask

    // Writes all four registers back to back; only called with the block idle.
    task automatic set_config(input cfg_t c);
        write_reg(CFG_MODE, c.mode);
        write_reg(CFG_STRIP, c.strip_high_bit);
        write_reg(CFG_ALLOWBIN, c.allow_binary);
        write_reg(CFG_TRUNC, c.truncate_at_ctrlz);
        cfg_valid <= 1'b0;
    endtask

    // Waits for every predicted word, then for words that cause no result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (converted_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly text-like bytes with many line endings, a little noise.
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 24);
        if (r < 6)
            return CH_CR;
        else if (r < 11)
            return CH_LF;
        else if (r < 13)
            return CH_CTRLZ;
        else if (r == 13)
            return 8'($urandom_range(0, 255));
        else if (r == 14)
            return (($urandom_range(0, 1) == 0) ? CH_CR : CH_LF) | 8'h80;
        else
            return 8'($urandom_range(7, 126));
    endfunction

    // Reset settings: to-LF, binary rejected, no truncation.
    task automatic test_to_lf_defaults();
        send_word(ACT_DATA, 8'h07);
        send_word(ACT_DATA, CH_CR);
        send_word(ACT_DATA, CH_LF);
        send_word(ACT_DATA, CH_CR);
        send_word(ACT_DATA, CH_CR);
        send_word(ACT_DATA, 8'h7E);
        send_word(ACT_DATA, CH_CTRLZ);
        send_word(ACT_DATA, 8'h41);
        send_word(ACT_DATA, CH_CTRLZ);
        end_stream();
        send_word(ACT_DATA, CH_CR);
        end_stream();
    endtask

    task automatic test_to_crlf();
        wait_drained();
        set_config(make_cfg(MODE_TO_CRLF, 1'b0, 1'b0, 1'b0));
        send_word(ACT_DATA, CH_LF);
        send_word(ACT_DATA, CH_CR);
        send_word(ACT_DATA, CH_LF);
        send_word(ACT_DATA, CH_CTRLZ);
        end_stream();
    endtask

    task automatic test_truncate();
        wait_drained();
        set_config(make_cfg(MODE_TO_LF, 1'b0, 1'b0, 1'b1));
        send_word(ACT_DATA, CH_CTRLZ);
        send_word(ACT_DATA, 8'h41);
        end_stream();
    endtask

    task automatic test_reject_and_strip();
        wait_drained();
        set_config(make_cfg(MODE_TO_LF, 1'b0, 1'b0, 1'b0));
        send_word(ACT_DATA, CH_CR);
        send_word(ACT_DATA, 8'h00);
        end_stream();
        // Stripping after the binary check turns 8D and 8A into CR and LF.
        wait_drained();
        set_config(make_cfg(MODE_TO_LF, 1'b1, 1'b1, 1'b0));
        send_word(ACT_DATA, 8'hFF);
        send_word(ACT_DATA, 8'h8D);
        send_word(ACT_DATA, 8'h8A);
        end_stream();
    endtask

    // A CR held in to-LF mode is not emitted once the mode changes.
    task automatic test_mode_switch();
        wait_drained();
        set_config(make_cfg(MODE_TO_LF, 1'b0, 1'b0, 1'b0));
        send_word(ACT_DATA, CH_CR);
        wait_drained();
        set_config(make_cfg(MODE_TO_CRLF, 1'b0, 1'b0, 1'b0));
        send_word(ACT_DATA, CH_LF);
        end_stream();
    endtask

    // Random streams over several settings; streams may span a change.
    task automatic test_random_streams();
        cfg_t c;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
                c = '0;
            else if (p == 1)
                c = '1;
            else
                c = cfg_t'(4'($urandom_range(0, 15)));
            set_config(c);
            in_gap_max   = (p % 3 == 0) ? 0 : 16;
            out_wait_max = (p % 4 == 1) ? 0 : 16;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (stream_left == 0)
                begin
                    end_stream();
                    stream_left = $urandom_range(1, 20);
                end
                else
                begin
                    send_word(ACT_DATA, pick_text_byte());
                    stream_left = stream_left - 1;
                end
            end
        end
    endtask

    // Output side: check each word taken, then stall for a random count.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (converted_q.size() == 0)
            begin
                $error("unexpected word: kind %0d out_byte 0x%02h last %0b",
                       kind, out_byte, last);
                fail_count++;
            end
            else
            begin
                want = converted_q.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    fail_count++;
                end
                if (out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_byte);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    fail_count++;
                end
            end
            out_wait_left = $urandom_range(0, out_wait_max);
        end
        else if (out_wait_left > 0)
            out_wait_left = out_wait_left - 1;
        out_stall <= (out_wait_left > 0);
    end

    // Watchdog on cycles in which no channel moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $error("no word moved for %0d cycles", quiet_cycles);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_to_lf_defaults();
        test_to_crlf();
        test_truncate();
        test_reject_and_strip();
        test_mode_switch();
        test_random_streams();
        wait_drained();
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/nlc_pkg.sv
src/nlc_core.sv
src/nlc_outq.sv
src/newline_convert.sv
verif/tb_top.sv
